// ----- src/biou_pkg.sv -----
// Shared types for the box intersection-over-union pipeline.
package biou_pkg;

  typedef struct packed {
    logic valid;
    logic degen;
  } biou_ctl_t;

endpackage

// ----- src/biou_front.sv -----
// Front end: box extents, areas, union and divider operands over four stages.
module biou_front import biou_pkg::*; #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           take_i,
  input  logic signed [COORD_BITS-1:0]   a_left_i,
  input  logic signed [COORD_BITS-1:0]   a_top_i,
  input  logic signed [COORD_BITS-1:0]   a_right_i,
  input  logic signed [COORD_BITS-1:0]   a_bottom_i,
  input  logic signed [COORD_BITS-1:0]   b_left_i,
  input  logic signed [COORD_BITS-1:0]   b_top_i,
  input  logic signed [COORD_BITS-1:0]   b_right_i,
  input  logic signed [COORD_BITS-1:0]   b_bottom_i,
  output biou_ctl_t                      ctl_o,
  output logic [2*COORD_BITS+2:0]        dividend_o,
  output logic [2*COORD_BITS+1:0]        divisor_o,
  output logic [2*COORD_BITS:0]          area_o
);

  localparam int unsigned EW    = COORD_BITS + 2;
  localparam int unsigned IW    = COORD_BITS + 1;
  localparam int unsigned AW    = 2 * COORD_BITS + 2;
  localparam int unsigned SW    = 2 * COORD_BITS + 3;
  localparam int unsigned UW    = 2 * COORD_BITS + 4;
  localparam int unsigned AREAW = 2 * COORD_BITS + 1;
  localparam int unsigned RW    = 2 * COORD_BITS + 3;
  localparam int unsigned DW    = 2 * COORD_BITS + 2;

  // Stage one: extents.
  logic signed [COORD_BITS-1:0] lo_x, hi_x, lo_y, hi_y;
  logic signed [EW-1:0]         ext_x, ext_y;
  logic [IW-1:0]                iw_d, ih_d;
  logic signed [EW-1:0]         wa_d, ha_d, wb_d, hb_d;
  logic                         v1_q;
  logic [IW-1:0]                iw_q, ih_q;
  logic signed [EW-1:0]         wa_q, ha_q, wb_q, hb_q;

  always_comb begin
    lo_x  = (a_left_i > b_left_i) ? a_left_i : b_left_i;
    hi_x  = (a_right_i < b_right_i) ? a_right_i : b_right_i;
    lo_y  = (a_top_i > b_top_i) ? a_top_i : b_top_i;
    hi_y  = (a_bottom_i < b_bottom_i) ? a_bottom_i : b_bottom_i;
    ext_x = EW'(hi_x) - EW'(lo_x) + EW'(1);
    ext_y = EW'(hi_y) - EW'(lo_y) + EW'(1);
    iw_d  = ext_x[EW-1] ? '0 : ext_x[IW-1:0];
    ih_d  = ext_y[EW-1] ? '0 : ext_y[IW-1:0];
    wa_d  = EW'(a_right_i) - EW'(a_left_i) + EW'(1);
    ha_d  = EW'(a_bottom_i) - EW'(a_top_i) + EW'(1);
    wb_d  = EW'(b_right_i) - EW'(b_left_i) + EW'(1);
    hb_d  = EW'(b_bottom_i) - EW'(b_top_i) + EW'(1);
  end

  // Stage two: products.
  logic [2*IW-1:0]        inter_full;
  logic signed [2*EW-1:0] area_a_full, area_b_full;
  logic                   v2_q;
  logic [AREAW-1:0]       inter2_q;
  logic signed [AW-1:0]   area_a_q, area_b_q;

  always_comb begin
    inter_full  = iw_q * ih_q;
    area_a_full = wa_q * ha_q;
    area_b_full = wb_q * hb_q;
  end

  // Stage three: sum of own areas.
  logic                 v3_q;
  logic [AREAW-1:0]     inter3_q;
  logic signed [SW-1:0] sum_ab_d, sum_ab_q;

  assign sum_ab_d = SW'(area_a_q) + SW'(area_b_q);

  // Stage four: union and divider operands.
  logic signed [UW-1:0] uni;
  logic                 degen_d;
  biou_ctl_t            ctl_q;
  logic [RW-1:0]        dividend_q;
  logic [DW-1:0]        divisor_q;
  logic [AREAW-1:0]     inter4_q;

  always_comb begin
    uni     = UW'(sum_ab_q) - UW'($signed({1'b0, inter3_q}));
    degen_d = uni[UW-1] | (uni == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      ctl_q <= '0;
    end else begin
      v1_q        <= take_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      ctl_q.valid <= v3_q;
      ctl_q.degen <= degen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iw_q       <= iw_d;
    ih_q       <= ih_d;
    wa_q       <= wa_d;
    ha_q       <= ha_d;
    wb_q       <= wb_d;
    hb_q       <= hb_d;
    inter2_q   <= inter_full[AREAW-1:0];
    area_a_q   <= area_a_full[AW-1:0];
    area_b_q   <= area_b_full[AW-1:0];
    inter3_q   <= inter2_q;
    sum_ab_q   <= sum_ab_d;
    inter4_q   <= inter3_q;
    dividend_q <= degen_d ? '0 : RW'(inter3_q);
    divisor_q  <= degen_d ? DW'(1) : uni[DW-1:0];
  end

  assign ctl_o      = ctl_q;
  assign dividend_o = dividend_q;
  assign divisor_o  = divisor_q;
  assign area_o     = inter4_q;

endmodule

// ----- src/biou_divider.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module biou_divider import biou_pkg::*; #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  biou_ctl_t               ctl_i,
  input  logic [2*COORD_BITS+2:0] dividend_i,
  input  logic [2*COORD_BITS+1:0] divisor_i,
  input  logic [2*COORD_BITS:0]   area_i,
  output biou_ctl_t               ctl_o,
  output logic [FRAC_BITS:0]      quotient_o,
  output logic [2*COORD_BITS:0]   area_o
);

  localparam int unsigned RW    = 2 * COORD_BITS + 3;
  localparam int unsigned DW    = 2 * COORD_BITS + 2;
  localparam int unsigned AREAW = 2 * COORD_BITS + 1;
  localparam int unsigned QW    = FRAC_BITS + 1;
  localparam int unsigned NS    = FRAC_BITS + 1;

  biou_ctl_t        ctl_q  [NS];
  logic [RW-1:0]    rem_q  [NS];
  logic [QW-1:0]    quo_q  [NS];
  logic [DW-1:0]    div_q  [NS];
  logic [AREAW-1:0] area_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    biou_ctl_t        ctl_in;
    logic [RW-1:0]    rem_in, trial;
    logic [QW-1:0]    quo_in;
    logic [DW-1:0]    dv_in;
    logic [AREAW-1:0] area_in;
    logic             take;

    if (k == 0) begin : g_first
      assign ctl_in  = ctl_i;
      assign rem_in  = dividend_i;
      assign quo_in  = '0;
      assign dv_in   = divisor_i;
      assign area_in = area_i;
      assign trial   = rem_in;
    end else begin : g_next
      assign ctl_in  = ctl_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign dv_in   = div_q[k-1];
      assign area_in = area_q[k-1];
      assign trial   = {rem_in[RW-2:0], 1'b0};
    end

    assign take = (trial >= RW'(dv_in));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k] <= '0;
      end else begin
        ctl_q[k] <= ctl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= take ? (trial - RW'(dv_in)) : trial;
      quo_q[k]  <= {quo_in[QW-2:0], take};
      div_q[k]  <= dv_in;
      area_q[k] <= area_in;
    end
  end

  assign ctl_o      = ctl_q[NS-1];
  assign quotient_o = quo_q[NS-1];
  assign area_o     = area_q[NS-1];

endmodule

// ----- src/box_iou_unit.sv -----
// Top level of the box intersection-over-union pipeline.
//
//   Channel   Direction  Handshake            Payload
//   command   in         start_i, busy_o      a_*_i, b_*_i box corners
//   result    out        done_o strobe        overlap_ratio_o, overlap_area_o, degenerate_o
//
// One transaction is taken every cycle; busy_o never rises.
// Each result passes through four front-end stages, the divider with one stage per
// quotient bit, and an output register.
// Reset clears all valid bits; transactions in flight are dropped.
// The receiver cannot stall, so the pipeline never holds.
module box_iou_unit import biou_pkg::*; #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [COORD_BITS-1:0] a_left_i,
  input  logic signed [COORD_BITS-1:0] a_top_i,
  input  logic signed [COORD_BITS-1:0] a_right_i,
  input  logic signed [COORD_BITS-1:0] a_bottom_i,
  input  logic signed [COORD_BITS-1:0] b_left_i,
  input  logic signed [COORD_BITS-1:0] b_top_i,
  input  logic signed [COORD_BITS-1:0] b_right_i,
  input  logic signed [COORD_BITS-1:0] b_bottom_i,
  output logic                         done_o,
  output logic [FRAC_BITS:0]           overlap_ratio_o,
  output logic [2*COORD_BITS:0]        overlap_area_o,
  output logic                         degenerate_o
);

  localparam int unsigned QW = FRAC_BITS + 1;
  localparam logic [QW-1:0] RatioOne = {1'b1, {FRAC_BITS{1'b0}}};

  biou_ctl_t                 front_ctl, div_ctl;
  logic [2*COORD_BITS+2:0]   dividend;
  logic [2*COORD_BITS+1:0]   divisor;
  logic [2*COORD_BITS:0]     front_area, div_area;
  logic [QW-1:0]             quotient;

  logic                      done_q;
  logic                      degen_q;
  logic [QW-1:0]             ratio_d, ratio_q;
  logic [2*COORD_BITS:0]     area_q;

  assign busy_o = 1'b0;

  biou_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (start_i & ~busy_o),
    .a_left_i   (a_left_i),
    .a_top_i    (a_top_i),
    .a_right_i  (a_right_i),
    .a_bottom_i (a_bottom_i),
    .b_left_i   (b_left_i),
    .b_top_i    (b_top_i),
    .b_right_i  (b_right_i),
    .b_bottom_i (b_bottom_i),
    .ctl_o      (front_ctl),
    .dividend_o (dividend),
    .divisor_o  (divisor),
    .area_o     (front_area)
  );

  biou_divider #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (front_ctl),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .area_i     (front_area),
    .ctl_o      (div_ctl),
    .quotient_o (quotient),
    .area_o     (div_area)
  );

  assign ratio_d = (quotient > RatioOne) ? RatioOne : quotient;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= div_ctl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    ratio_q <= ratio_d;
    area_q  <= div_area;
    degen_q <= div_ctl.degen;
  end

  assign done_o          = done_q;
  assign overlap_ratio_o = ratio_q;
  assign overlap_area_o  = area_q;
  assign degenerate_o    = degen_q;

endmodule

// ----- src/biou_checker.sv -----
// Port-level checker for the box intersection-over-union unit, with its bind.
module biou_checker #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start_i,
  input logic                         busy_o,
  input logic signed [COORD_BITS-1:0] a_left_i,
  input logic signed [COORD_BITS-1:0] a_top_i,
  input logic signed [COORD_BITS-1:0] a_right_i,
  input logic signed [COORD_BITS-1:0] a_bottom_i,
  input logic signed [COORD_BITS-1:0] b_left_i,
  input logic signed [COORD_BITS-1:0] b_top_i,
  input logic signed [COORD_BITS-1:0] b_right_i,
  input logic signed [COORD_BITS-1:0] b_bottom_i,
  input logic                         done_o,
  input logic [FRAC_BITS:0]           overlap_ratio_o,
  input logic [2*COORD_BITS:0]        overlap_area_o,
  input logic                         degenerate_o
);

  localparam int unsigned Latency = FRAC_BITS + 6;
  localparam logic [FRAC_BITS:0] RatioOne = {1'b1, {FRAC_BITS{1'b0}}};

  // Every accepted transaction yields a result on done_o.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##Latency done_o)
    else $error("Accepted transaction produced no result on time.");

  // No result appears without a matching accepted transaction.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, Latency))
    else $error("Result without a matching accepted transaction.");

  a_ratio_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (overlap_ratio_o <= RatioOne))
    else $error("Ratio exceeds one.");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && degenerate_o) |-> (overlap_ratio_o == '0))
    else $error("Degenerate result carries a nonzero ratio.");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (overlap_area_o == '0)) |-> (overlap_ratio_o == '0))
    else $error("Empty intersection with a nonzero ratio.");

endmodule

bind box_iou_unit biou_checker #(
  .COORD_BITS(COORD_BITS),
  .FRAC_BITS (FRAC_BITS)
) u_biou_checker (.*);

// ----- verif/box_iou_unit_check.sv -----
// Checker that predicts the overlap result of each box pair and compares it with the block.
`timescale 1ns / 1ps
module box_iou_unit_check #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  logic signed [COORD_BITS-1:0] a_left_i,
  input  logic signed [COORD_BITS-1:0] a_top_i,
  input  logic signed [COORD_BITS-1:0] a_right_i,
  input  logic signed [COORD_BITS-1:0] a_bottom_i,
  input  logic signed [COORD_BITS-1:0] b_left_i,
  input  logic signed [COORD_BITS-1:0] b_top_i,
  input  logic signed [COORD_BITS-1:0] b_right_i,
  input  logic signed [COORD_BITS-1:0] b_bottom_i,
  input  logic                         done_i,
  input  logic [FRAC_BITS:0]           overlap_ratio_i,
  input  logic [2*COORD_BITS:0]        overlap_area_i,
  input  logic                         degenerate_i,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           checked_o,
  output int                           degenerate_seen_o,
  output int                           full_overlap_o
);

  typedef struct packed {
    logic [FRAC_BITS:0]    ratio;
    logic [2*COORD_BITS:0] area;
    logic                  degen;
  } overlap_t;

  localparam longint RATIO_ONE = longint'(1) << FRAC_BITS;
  localparam int     PTR_BITS  = 6;
  localparam int     DEPTH     = 1 << PTR_BITS;

  overlap_t            want_mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr = '0;
  logic [PTR_BITS-1:0] rd_ptr = '0;
  int                  outstanding;

  function automatic overlap_t predict_overlap(
    input logic signed [COORD_BITS-1:0] al, at, ar, ab, bl, bt, br, bb
  );
    longint   lo_x, hi_x, lo_y, hi_y, iw, ih, inter, area_a, area_b, uni, ratio;
    overlap_t res;
    lo_x = (al > bl) ? al : bl;
    hi_x = (ar < br) ? ar : br;
    lo_y = (at > bt) ? at : bt;
    hi_y = (ab < bb) ? ab : bb;
    iw = hi_x - lo_x + 1;
    ih = hi_y - lo_y + 1;
    if (iw < 0) iw = 0;
    if (ih < 0) ih = 0;
    inter  = iw * ih;
    area_a = (longint'(ar) - longint'(al) + 1) * (longint'(ab) - longint'(at) + 1);
    area_b = (longint'(br) - longint'(bl) + 1) * (longint'(bb) - longint'(bt) + 1);
    uni    = area_a + area_b - inter;
    ratio  = 0;
    res.degen = (uni <= 0);
    if (!res.degen) begin
      ratio = (inter << FRAC_BITS) / uni;
      if (ratio > RATIO_ONE) ratio = RATIO_ONE;
    end
    res.ratio = ratio[FRAC_BITS:0];
    res.area  = inter[2*COORD_BITS:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    overlap_t want;
    if (!rst_ni) begin
      wr_ptr      = '0;
      rd_ptr      = '0;
      outstanding = 0;
      pending_o   = 0;
    end else begin
      if (done_i) begin
        if (outstanding == 0) begin
          $display("%0t: result with no transaction outstanding, expected none, got ratio %0d",
                   $time, overlap_ratio_i);
          fail_count_o++;
        end else begin
          want        = want_mem[rd_ptr];
          rd_ptr      = rd_ptr + PTR_BITS'(1);
          outstanding = outstanding - 1;
          checked_o++;
          if (want.degen) degenerate_seen_o++;
          if (want.ratio == RATIO_ONE) full_overlap_o++;
          if (overlap_ratio_i !== want.ratio) begin
            $display("%0t: overlap_ratio expected %0d, got %0d", $time, want.ratio,
                     overlap_ratio_i);
            fail_count_o++;
          end
          if (overlap_area_i !== want.area) begin
            $display("%0t: overlap_area expected %0d, got %0d", $time, want.area,
                     overlap_area_i);
            fail_count_o++;
          end
          if (degenerate_i !== want.degen) begin
            $display("%0t: degenerate expected %0b, got %0b", $time, want.degen,
                     degenerate_i);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        want_mem[wr_ptr] = predict_overlap(a_left_i, a_top_i, a_right_i, a_bottom_i,
                                           b_left_i, b_top_i, b_right_i, b_bottom_i);
        wr_ptr      = wr_ptr + PTR_BITS'(1);
        outstanding = outstanding + 1;
      end
      pending_o = outstanding;
    end
  end

endmodule

// ----- verif/box_iou_unit_test.sv -----
// Testbench top for box_iou_unit: clock, reset, box pair stimulus and verdict.
`timescale 1ns / 1ps
module box_iou_unit_test;

  localparam int unsigned COORD_BITS   = 16;
  localparam int unsigned FRAC_BITS    = 16;
  localparam int          DRAIN_CYCLES = FRAC_BITS + 12;
  localparam int          RANDOM_PAIRS = 445;

  typedef struct {
    logic signed [COORD_BITS-1:0] left;
    logic signed [COORD_BITS-1:0] top;
    logic signed [COORD_BITS-1:0] right;
    logic signed [COORD_BITS-1:0] bottom;
  } box_t;

  logic                         clk_i;
  logic                         rst_ni     = 1'b0;
  logic                         start_i    = 1'b0;
  logic                         busy_o;
  logic signed [COORD_BITS-1:0] a_left_i   = '0;
  logic signed [COORD_BITS-1:0] a_top_i    = '0;
  logic signed [COORD_BITS-1:0] a_right_i  = '0;
  logic signed [COORD_BITS-1:0] a_bottom_i = '0;
  logic signed [COORD_BITS-1:0] b_left_i   = '0;
  logic signed [COORD_BITS-1:0] b_top_i    = '0;
  logic signed [COORD_BITS-1:0] b_right_i  = '0;
  logic signed [COORD_BITS-1:0] b_bottom_i = '0;
  logic                         done_o;
  logic [FRAC_BITS:0]           overlap_ratio_o;
  logic [2*COORD_BITS:0]        overlap_area_o;
  logic                         degenerate_o;

  int fail_count;
  int pending;
  int checked;
  int degenerate_seen;
  int full_overlap;
  int pairs_sent;
  int idle_pct;

  box_iou_unit #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .a_left_i       (a_left_i),
    .a_top_i        (a_top_i),
    .a_right_i      (a_right_i),
    .a_bottom_i     (a_bottom_i),
    .b_left_i       (b_left_i),
    .b_top_i        (b_top_i),
    .b_right_i      (b_right_i),
    .b_bottom_i     (b_bottom_i),
    .done_o         (done_o),
    .overlap_ratio_o(overlap_ratio_o),
    .overlap_area_o (overlap_area_o),
    .degenerate_o   (degenerate_o)
  );

  box_iou_unit_check #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) overlap_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_i           (busy_o),
    .a_left_i         (a_left_i),
    .a_top_i          (a_top_i),
    .a_right_i        (a_right_i),
    .a_bottom_i       (a_bottom_i),
    .b_left_i         (b_left_i),
    .b_top_i          (b_top_i),
    .b_right_i        (b_right_i),
    .b_bottom_i       (b_bottom_i),
    .done_i           (done_o),
    .overlap_ratio_i  (overlap_ratio_o),
    .overlap_area_i   (overlap_area_o),
    .degenerate_i     (degenerate_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .checked_o        (checked),
    .degenerate_seen_o(degenerate_seen),
    .full_overlap_o   (full_overlap)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic logic signed [COORD_BITS-1:0] rand_coord();
    return COORD_BITS'($urandom);
  endfunction

  function automatic int rand_offset(input int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // A width or height of zero or less gives an inverted box.
  function automatic box_t box_at(input int l, input int t, input int w, input int h);
    box_t bx;
    bx.left   = COORD_BITS'(l);
    bx.top    = COORD_BITS'(t);
    bx.right  = COORD_BITS'(l + w - 1);
    bx.bottom = COORD_BITS'(t + h - 1);
    return bx;
  endfunction

  task automatic send_pair(input box_t a, input box_t b);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i    <= 1'b1;
    a_left_i   <= a.left;
    a_top_i    <= a.top;
    a_right_i  <= a.right;
    a_bottom_i <= a.bottom;
    b_left_i   <= b.left;
    b_top_i    <= b.top;
    b_right_i  <= b.right;
    b_bottom_i <= b.bottom;
    do @(posedge clk_i); while (busy_o);
    pairs_sent++;
  endtask

  task automatic random_pair();
    box_t a, b;
    int   kind, x0, y0;
    kind = $urandom_range(99);
    x0   = rand_coord();
    y0   = rand_coord();
    a    = box_at(x0, y0, $urandom_range(1, 64), $urandom_range(1, 64));
    if (kind < 50) begin
      b = box_at(x0 + rand_offset(48), y0 + rand_offset(48),
                 $urandom_range(1, 64), $urandom_range(1, 64));
    end else if (kind < 58) begin
      b = a;
    end else if (kind < 66) begin
      b = box_at(a.left - int'($urandom_range(20)), a.top - int'($urandom_range(20)),
                 a.right - a.left + 1 + int'($urandom_range(40)),
                 a.bottom - a.top + 1 + int'($urandom_range(40)));
    end else if (kind < 81) begin
      a = '{rand_coord(), rand_coord(), rand_coord(), rand_coord()};
      b = '{rand_coord(), rand_coord(), rand_coord(), rand_coord()};
    end else if (kind < 92) begin
      a = box_at(x0, y0, rand_offset(12), rand_offset(12));
      b = box_at(x0 + rand_offset(8), y0 + rand_offset(8), rand_offset(12), rand_offset(12));
    end else begin
      a = box_at(-32768 + int'($urandom_range(300)), -32768 + int'($urandom_range(300)),
                 65536 - int'($urandom_range(600)), 65536 - int'($urandom_range(600)));
      b = box_at(-32768 + int'($urandom_range(40000)), -32768 + int'($urandom_range(40000)),
                 int'($urandom_range(1, 30000)), int'($urandom_range(1, 30000)));
      if ($urandom_range(1)) b = a;
    end
    send_pair(a, b);
  endtask

  initial begin
    idle_pct = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    idle_pct = 11;
    send_pair(box_at(0, 0, 1, 1), box_at(0, 0, 1, 1));
    send_pair(box_at(-32768, -32768, 65536, 65536), box_at(-32768, -32768, 65536, 65536));
    send_pair(box_at(-32768, -32768, 65536, 65536), box_at(32767, 32767, 1, 1));
    send_pair(box_at(0, 0, 10, 10), box_at(100, 100, 10, 10));
    send_pair(box_at(0, 0, 10, 10), box_at(10, 0, 10, 10));
    send_pair(box_at(0, 0, 10, 10), box_at(9, 0, 10, 10));
    send_pair(box_at(0, 0, 20, 10), box_at(10, 0, 20, 10));
    send_pair(box_at(0, 0, 100, 100), box_at(10, 10, 5, 5));
    send_pair(box_at(10, 0, -5, 10), box_at(0, 0, 20, 20));
    send_pair(box_at(10, 10, -5, -5), box_at(0, 0, 20, 20));
    send_pair(box_at(0, 0, 0, 10), box_at(5, 5, 0, 3));
    send_pair(box_at(0, 0, -9, 10), box_at(0, 0, 10, -9));
    send_pair(box_at(0, 0, -9, 10), box_at(50, 50, 20, 10));
    send_pair(box_at(32767, 32767, 1, 1), box_at(32767, 32767, 1, 1));
    send_pair(box_at(-32768, -32768, 1, 1), box_at(-32768, -32768, 1, 1));
    send_pair(box_at(32767, 32767, 1, 1), box_at(-32768, -32768, 1, 1));
    send_pair(box_at(-32768, -32768, 65536, 65536), box_at(32767, 32767, -65534, -65534));
    send_pair(box_at(32767, -32768, -65534, 65536), box_at(32767, -32768, -65534, 65536));
    send_pair(box_at(-100, -100, 201, 201), box_at(-50, 0, 100, 300));

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 11 : (phase == 1) ? 71 : 0;
      repeat (RANDOM_PAIRS) random_pair();
    end

    @(negedge clk_i);
    start_i <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d box pairs at three idle rates; compared %0d results.", pairs_sent,
             checked);
    $display("Of those, %0d had a non-positive union and %0d a ratio of exactly one.",
             degenerate_seen, full_overlap);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/biou_pkg.sv
src/biou_front.sv
src/biou_divider.sv
src/box_iou_unit.sv
src/biou_checker.sv
verif/box_iou_unit_check.sv
verif/box_iou_unit_test.sv
